@@ rtl/ogg_php_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ogg page header parser package
// Shared widths, result kind codes and capture pattern constants.
// ----------------------------------------------------------------------------
package ogg_php_pkg;

   localparam int KIND_W = 2;

   localparam logic [KIND_W-1:0] KIND_HEADER   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PACKET   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MISMATCH = 2'd2;

   localparam logic [7:0] LACE_FULL = 8'd255;

   localparam logic [7:0] MAGIC_O = 8'h4F;
   localparam logic [7:0] MAGIC_G = 8'h67;
   localparam logic [7:0] MAGIC_S = 8'h53;

   localparam logic [1:0] MAGIC_LAST = 2'd3;

   localparam logic [4:0] HDR_VERSION   = 5'd0;
   localparam logic [4:0] HDR_FLAGS     = 5'd1;
   localparam logic [4:0] HDR_SERIAL    = 5'd10;
   localparam logic [4:0] HDR_SEQUENCE  = 5'd14;
   localparam logic [4:0] HDR_CHECKSUM  = 5'd18;
   localparam logic [4:0] HDR_SEGMENTS  = 5'd22;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] value;
      case (idx)
         2'd0:    value = MAGIC_O;
         2'd1:    value = MAGIC_G;
         2'd2:    value = MAGIC_G;
         default: value = MAGIC_S;
      endcase
      return value;
   endfunction

endpackage
`default_nettype wire

@@ rtl/ogg_page_header_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ogg page header parser
// Finds the capture pattern, gathers the page header fields, sums lacing
// values into packet lengths and skips the page body, one byte per request.
// ----------------------------------------------------------------------------
// Results are registered: a result appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle unless a held result stalls the input; state
// updates once per byte and the result register is refilled while it is taken.
// Reset: synchronous; the parser returns to the pattern search with all
// counters and header registers cleared, and no result pending.
// ----------------------------------------------------------------------------
module ogg_page_header_parser
   import ogg_php_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [7:0]         rsp_version,
   output logic [7:0]         rsp_header_flags,
   output logic signed [63:0] rsp_granule_position,
   output logic [31:0]        rsp_serial_number,
   output logic [31:0]        rsp_sequence_number,
   output logic [31:0]        rsp_page_checksum,
   output logic [7:0]         rsp_segment_count,
   output logic [15:0]        rsp_packet_length,
   output logic               rsp_packet_complete,
   output logic [7:0]         rsp_packet_number,
   output logic               rsp_last_of_page
);

   localparam logic [2:0] PH_MAGIC  = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_LACING = 3'd2;
   localparam logic [2:0] PH_BODY   = 3'd3;

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  count_ff, count_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  flags_ff, flags_in;
   logic [63:0] granule_ff, granule_in;
   logic [31:0] serial_ff, serial_in;
   logic [31:0] sequence_ff, sequence_in;
   logic [31:0] checksum_ff, checksum_in;
   logic [7:0]  seg_left_ff, seg_left_in;
   logic [15:0] pkt_acc_ff, pkt_acc_in;
   logic [7:0]  pkt_cnt_ff, pkt_cnt_in;
   logic [15:0] body_left_ff, body_left_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        emit;
   logic [KIND_W-1:0] kind_in;
   logic [15:0] pkt_len_in;
   logic        pkt_done_in;
   logic        last_in;

   logic [KIND_W-1:0] kind_ff;
   logic [7:0]  o_version_ff, o_flags_ff, o_segments_ff, o_pkt_num_ff;
   logic [63:0] o_granule_ff;
   logic [31:0] o_serial_ff, o_sequence_ff, o_checksum_ff;
   logic [15:0] o_pkt_len_ff;
   logic        o_pkt_done_ff, o_last_ff;

   logic        accept;
   logic [7:0]  b;
   logic [15:0] acc_sum, body_sum;
   logic [7:0]  seg_dec;

   assign b         = req_data_byte;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign acc_sum   = pkt_acc_ff + {8'd0, b};
   assign body_sum  = body_left_ff + {8'd0, b};
   assign seg_dec   = seg_left_ff - 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      version_in   = version_ff;
      flags_in     = flags_ff;
      granule_in   = granule_ff;
      serial_in    = serial_ff;
      sequence_in  = sequence_ff;
      checksum_in  = checksum_ff;
      seg_left_in  = seg_left_ff;
      pkt_acc_in   = pkt_acc_ff;
      pkt_cnt_in   = pkt_cnt_ff;
      body_left_in = body_left_ff;
      emit         = 1'b0;
      kind_in      = KIND_MISMATCH;
      pkt_len_in   = 16'd0;
      pkt_done_in  = 1'b0;
      last_in      = 1'b0;
      case (phase_ff)
         PH_MAGIC: begin
            if (b == magic_byte(count_ff[1:0])) begin
               if (count_ff[1:0] == MAGIC_LAST) begin
                  phase_in = PH_HEADER;
                  count_in = 5'd0;
               end else begin
                  count_in = {3'd0, count_ff[1:0] + 2'd1};
               end
            end else begin
               count_in = (b == MAGIC_O) ? 5'd1 : 5'd0;
               emit     = 1'b1;
               kind_in  = KIND_MISMATCH;
            end
         end
         PH_HEADER: begin
            count_in = count_ff + 5'd1;
            if (count_ff == HDR_VERSION) begin
               version_in = b;
            end else if (count_ff == HDR_FLAGS) begin
               flags_in = b;
            end else if (count_ff < HDR_SERIAL) begin
               granule_in = {b, granule_ff[63:8]};
            end else if (count_ff < HDR_SEQUENCE) begin
               serial_in = {b, serial_ff[31:8]};
            end else if (count_ff < HDR_CHECKSUM) begin
               sequence_in = {b, sequence_ff[31:8]};
            end else if (count_ff < HDR_SEGMENTS) begin
               checksum_in = {b, checksum_ff[31:8]};
            end else begin
               seg_left_in  = b;
               pkt_acc_in   = 16'd0;
               pkt_cnt_in   = 8'd0;
               body_left_in = 16'd0;
               count_in     = 5'd0;
               phase_in     = (b == 8'd0) ? PH_MAGIC : PH_LACING;
               emit         = 1'b1;
               kind_in      = KIND_HEADER;
            end
         end
         PH_LACING: begin
            pkt_acc_in   = acc_sum;
            body_left_in = body_sum;
            seg_left_in  = seg_dec;
            if (b < LACE_FULL || seg_dec == 8'd0) begin
               emit        = 1'b1;
               kind_in     = KIND_PACKET;
               pkt_len_in  = acc_sum;
               pkt_done_in = (b < LACE_FULL);
               last_in     = (seg_dec == 8'd0);
               pkt_cnt_in  = pkt_cnt_ff + 8'd1;
               pkt_acc_in  = 16'd0;
            end
            if (seg_dec == 8'd0) begin
               phase_in = (body_sum != 16'd0) ? PH_BODY : PH_MAGIC;
               count_in = 5'd0;
            end
         end
         PH_BODY: begin
            body_left_in = body_left_ff - 16'd1;
            if (body_left_ff == 16'd1) begin
               phase_in = PH_MAGIC;
               count_in = 5'd0;
            end
         end
         default: begin
            phase_in = PH_MAGIC;
            count_in = 5'd0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         count_ff     <= 5'd0;
         version_ff   <= 8'd0;
         flags_ff     <= 8'd0;
         granule_ff   <= 64'd0;
         serial_ff    <= 32'd0;
         sequence_ff  <= 32'd0;
         checksum_ff  <= 32'd0;
         seg_left_ff  <= 8'd0;
         pkt_acc_ff   <= 16'd0;
         pkt_cnt_ff   <= 8'd0;
         body_left_ff <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            version_ff   <= version_in;
            flags_ff     <= flags_in;
            granule_ff   <= granule_in;
            serial_ff    <= serial_in;
            sequence_ff  <= sequence_in;
            checksum_ff  <= checksum_in;
            seg_left_ff  <= seg_left_in;
            pkt_acc_ff   <= pkt_acc_in;
            pkt_cnt_ff   <= pkt_cnt_in;
            body_left_ff <= body_left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff       <= kind_in;
         o_version_ff  <= (kind_in == KIND_HEADER) ? version_ff : 8'd0;
         o_flags_ff    <= (kind_in == KIND_HEADER) ? flags_ff : 8'd0;
         o_granule_ff  <= (kind_in == KIND_HEADER) ? granule_ff : 64'd0;
         o_serial_ff   <= (kind_in == KIND_HEADER) ? serial_ff : 32'd0;
         o_sequence_ff <= (kind_in == KIND_HEADER) ? sequence_ff : 32'd0;
         o_checksum_ff <= (kind_in == KIND_HEADER) ? checksum_ff : 32'd0;
         o_segments_ff <= (kind_in == KIND_HEADER) ? b : 8'd0;
         o_pkt_len_ff  <= pkt_len_in;
         o_pkt_done_ff <= pkt_done_in;
         o_pkt_num_ff  <= (kind_in == KIND_PACKET) ? pkt_cnt_ff : 8'd0;
         o_last_ff     <= last_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_version          = o_version_ff;
   assign rsp_header_flags     = o_flags_ff;
   assign rsp_granule_position = $signed(o_granule_ff);
   assign rsp_serial_number    = o_serial_ff;
   assign rsp_sequence_number  = o_sequence_ff;
   assign rsp_page_checksum    = o_checksum_ff;
   assign rsp_segment_count    = o_segments_ff;
   assign rsp_packet_length    = o_pkt_len_ff;
   assign rsp_packet_complete  = o_pkt_done_ff;
   assign rsp_packet_number    = o_pkt_num_ff;
   assign rsp_last_of_page     = o_last_ff;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("Parser stalled its input with no result pending.");

   a_result_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_valid && req_ready))
      else $error("A result appeared without an accepted request.");

   a_packet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_PACKET |->
         o_segments_ff == 8'd0 && o_granule_ff == 64'd0 && o_version_ff == 8'd0)
      else $error("Packet result carries header fields.");

   a_mismatch_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_MISMATCH |->
         o_pkt_len_ff == 16'd0 && !o_pkt_done_ff && !o_last_ff && o_pkt_num_ff == 8'd0)
      else $error("Mismatch result carries packet fields.");

   a_body_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> body_left_ff != 16'd0)
      else $error("Body phase entered with no body bytes left.");

endmodule
`default_nettype wire
